[design/rbp1d_pkg.sv]
// ============================================================================
// rbp1d_pkg
// Shared widths and saturating fixed-point helpers for the 1D Boris pusher.
// ============================================================================
package rbp1d_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int Q_W         = 32;
    localparam int POS_W       = 48;
    localparam int CELL_W      = 16;
    localparam int SPECIES_W   = 2;
    localparam int IN_DATA_W   = 304;
    localparam int OUT_DATA_W  = 176;
    localparam int DIV_STEPS   = 33;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // Clamp a wide signed value into the 32-bit range.
    function automatic logic signed [Q_W-1:0] f_sat(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = Q_MAX;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] f_qadd(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return f_sat(s);
    endfunction

    function automatic logic signed [Q_W-1:0] f_qsub(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return f_sat(s);
    endfunction

endpackage

[design/relativistic_boris_push_1d_core.sv]
// ============================================================================
// relativistic_boris_push_1d_core
// Fully pipelined relativistic Boris push and drift for one 1D PIC particle.
// ============================================================================
//
//  Channel     Direction  Beat contents (lowest bits first)
//  s_axis      in         tdata: cell_index, mom_x, mom_y, mom_z, pos_in_cell,
//                                field_ex, field_pr, field_pl, field_sr, field_sl
//                         tuser: species
//  m_axis      out        tdata: new_mom_x, new_mom_y, new_mom_z,
//                                new_pos_in_cell, old_position
//                         tuser: overspeed
//  cfg         in         write enable, register index, 32-bit data
//
// The pipeline takes one beat per cycle while the sink keeps up. Its depth,
// given by N_STG below, is set mostly by the two bit-per-stage square roots
// and the three bit-per-stage divider sections.
// Reset clears the valid bits and the coefficient registers only.
// The whole pipeline stalls as one when the last stage holds a beat that the
// sink does not take; nothing is dropped or repeated across a stall.
//
module relativistic_boris_push_1d_core
    import rbp1d_pkg::*;
#(
    parameter int NUM_SPECIES = 4,
    parameter int FRAC_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // cell_index[15:0], mom_x, mom_y, mom_z, pos_in_cell, field_ex,
    // field_pr, field_pl, field_sr, field_sl (32 bits each, upward)
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // species[1:0]
    input  logic [SPECIES_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // new_mom_x, new_mom_y, new_mom_z, new_pos_in_cell (32 bits each),
    // old_position[47:0] on top
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // overspeed
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [Q_W-1:0]        i_cfg_wdata
);

    // Square root of s << FRAC_BITS yields this many result bits.
    localparam int SQ_STEPS = (32 + FRAC_BITS) / 2;
    localparam int SQW      = 32 + FRAC_BITS;
    // Dividend magnitude: up to 33 bits shifted up by FRAC_BITS.
    localparam int NUMW     = 33 + FRAC_BITS;

    localparam logic signed [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

    // Stage map.
    localparam int P_KICK  = 1;
    localparam int P_HALF  = 2;
    localparam int P_SQA   = 3;
    localparam int P_SUMA  = 4;
    localparam int P_RTA   = 5;
    localparam int P_DIVA0 = P_RTA + SQ_STEPS;
    localparam int P_DIVA  = P_DIVA0 + 1;
    localparam int P_CG    = P_DIVA + DIV_STEPS;
    localparam int P_T     = P_CG + 1;
    localparam int P_TSQ   = P_T + 1;
    localparam int P_SQT   = P_TSQ + 1;
    localparam int P_DIVB  = P_SQT + 1;
    localparam int P_S     = P_DIVB + DIV_STEPS;
    localparam int P_PROD  = P_S + 1;
    localparam int P_MAT   = P_PROD + 1;
    localparam int P_MUL9  = P_MAT + 1;
    localparam int P_DOT   = P_MUL9 + 1;
    localparam int P_NEW   = P_DOT + 1;
    localparam int P_SQB   = P_NEW + 1;
    localparam int P_SUMB  = P_SQB + 1;
    localparam int P_RTB   = P_SUMB + 1;
    localparam int P_DIVC0 = P_RTB + SQ_STEPS;
    localparam int P_DIVC  = P_DIVC0 + 1;
    localparam int P_SHIFT = P_DIVC + DIV_STEPS;
    localparam int P_OUT   = P_SHIFT + 1;
    localparam int N_STG   = P_OUT + 1;

    typedef struct packed {
        logic            neg;
        logic [NUMW-1:0] num;
        logic [31:0]     den;
        logic [32:0]     rem;
        logic [32:0]     quo;
    } t_div;

    typedef struct packed {
        logic signed [31:0] coef, ex, ey, ez, by, bz;
        logic signed [31:0] kx, ky, kz, mx, my, mz, x1;
        logic signed [47:0] oldp;
        logic signed [31:0] t0, t1, t2, cg, ty, tz, sy, sz;
        logic signed [31:0] a1, a2, a3, a4, nx, ny, nz, shift, npos;
        logic [8:0][31:0]   mat;
        logic [SQW-1:0]     sq_v, sq_r;
        t_div               da, db;
        logic               ovs;
    } t_ctx;

    function automatic logic signed [31:0] f_qmul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return f_sat(p >>> FRAC_BITS);
    endfunction

    function automatic t_div f_div_init(input logic signed [32:0] a,
                                        input logic [31:0] den);
        t_div            d;
        logic [32:0]     mag;
        mag     = a[32] ? 33'(-a) : 33'(a);
        d.neg   = a[32];
        d.num   = NUMW'(mag) << FRAC_BITS;
        d.den   = den;
        d.rem   = 33'(d.num >> DIV_STEPS);
        d.quo   = '0;
        return d;
    endfunction

    // One restoring-division step: bring down one dividend bit.
    function automatic t_div f_div_step(input t_div d, input int j);
        t_div        r;
        logic [32:0] tmp;
        r   = d;
        tmp = {d.rem[31:0], d.num[j]};
        if (tmp >= {1'b0, d.den}) begin
            r.rem = tmp - {1'b0, d.den};
            r.quo = {d.quo[31:0], 1'b1};
        end else begin
            r.rem = tmp;
            r.quo = {d.quo[31:0], 1'b0};
        end
        return r;
    endfunction

    // Quotient truncates toward zero, then saturates.
    function automatic logic signed [31:0] f_div_done(input t_div d);
        logic signed [31:0] r;
        if (!d.neg) begin
            r = (d.quo > 33'h0_7FFF_FFFF) ? Q_MAX : d.quo[31:0];
        end else begin
            r = (d.quo > 33'h0_8000_0000) ? Q_MIN : 32'(-d.quo);
        end
        return r;
    endfunction

    // One digit of the integer square root; bit weight is 4**i.
    function automatic t_ctx f_sqrt_step(input t_ctx c, input int i);
        t_ctx           r;
        logic [SQW-1:0] b;
        logic [SQW-1:0] tb;
        r  = c;
        b  = SQW'(1) << (2 * i);
        tb = c.sq_r + b;
        if (c.sq_v >= tb) begin
            r.sq_v = c.sq_v - tb;
            r.sq_r = (c.sq_r >> 1) + b;
        end else begin
            r.sq_r = c.sq_r >> 1;
        end
        return r;
    endfunction

    logic signed [31:0] r_coef [NUM_SPECIES];
    t_ctx               r_ctx  [N_STG];
    t_ctx               n_ctx  [N_STG];
    t_ctx               n_stg0;
    logic [N_STG-1:0]   r_vld;
    logic               w_en;

    // Coefficient registers; writes to indexes without a register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SPECIES; s++) begin
                r_coef[s] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            for (int s = 0; s < NUM_SPECIES; s++) begin
                if (i_cfg_index == CFG_IDX_W'(s)) begin
                    r_coef[s] <= i_cfg_wdata;
                end
            end
        end
    end

    // Everything advances together unless the output beat is stuck.
    assign w_en            = !r_vld[N_STG-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Stage 0: unpack the beat, pick the coefficient and form the fields.
    always_comb begin
        t_ctx               c;
        logic signed [31:0] pr, pl, sr, sl;
        logic [47:0]        cell_sh;
        c       = '0;
        pr      = i_s_axis_tdata[207:176];
        pl      = i_s_axis_tdata[239:208];
        sr      = i_s_axis_tdata[271:240];
        sl      = i_s_axis_tdata[303:272];
        for (int s = 0; s < NUM_SPECIES; s++) begin
            if (i_s_axis_tuser == SPECIES_W'(s)) begin
                c.coef = r_coef[s];
            end
        end
        c.mx    = i_s_axis_tdata[47:16];
        c.my    = i_s_axis_tdata[79:48];
        c.mz    = i_s_axis_tdata[111:80];
        c.x1    = i_s_axis_tdata[143:112];
        c.ex    = i_s_axis_tdata[175:144];
        c.ey    = f_qadd(pr, pl);
        c.ez    = f_qadd(sr, sl);
        c.by    = f_qsub(sl, sr);
        c.bz    = f_qsub(pr, pl);
        cell_sh = 48'(i_s_axis_tdata[15:0]) << FRAC_BITS;
        c.oldp  = $signed(cell_sh) + 48'(c.x1);
        n_stg0  = c;
    end

    // Remaining stages; each one reads only the register in front of it.
    always_comb begin
        t_ctx c;
        n_ctx[0] = n_stg0;
        for (int k = 1; k < N_STG; k++) begin
            c = r_ctx[k-1];
            if (k == P_KICK) begin
                c.kx = f_qmul(c.coef, c.ex);
                c.ky = f_qmul(c.coef, c.ey);
                c.kz = f_qmul(c.coef, c.ez);
            end else if (k == P_HALF || k == P_NEW) begin
                if (k == P_HALF) begin
                    c.mx = f_qadd(c.mx, c.kx);
                    c.my = f_qadd(c.my, c.ky);
                    c.mz = f_qadd(c.mz, c.kz);
                end else begin
                    c.nx = f_qadd(c.nx, c.kx);
                    c.ny = f_qadd(c.ny, c.ky);
                    c.nz = f_qadd(c.nz, c.kz);
                end
            end else if (k == P_SQA) begin
                c.t0 = f_qmul(c.mx, c.mx);
                c.t1 = f_qmul(c.my, c.my);
                c.t2 = f_qmul(c.mz, c.mz);
            end else if (k == P_SQB) begin
                c.t0 = f_qmul(c.nx, c.nx);
                c.t1 = f_qmul(c.ny, c.ny);
                c.t2 = f_qmul(c.nz, c.nz);
            end else if (k == P_SUMA || k == P_SUMB) begin
                c.sq_v = SQW'(f_qadd(f_qadd(f_qadd(ONE, c.t0), c.t1), c.t2)) << FRAC_BITS;
                c.sq_r = '0;
            end else if (k >= P_RTA && k < P_RTA + SQ_STEPS) begin
                c = f_sqrt_step(c, SQ_STEPS - 1 - (k - P_RTA));
            end else if (k >= P_RTB && k < P_RTB + SQ_STEPS) begin
                c = f_sqrt_step(c, SQ_STEPS - 1 - (k - P_RTB));
            end else if (k == P_DIVA0) begin
                c.da = f_div_init(33'(c.coef), c.sq_r[31:0]);
            end else if (k == P_DIVC0) begin
                c.da = f_div_init(33'(c.nx), c.sq_r[31:0]);
            end else if (k >= P_DIVA && k < P_DIVA + DIV_STEPS) begin
                c.da = f_div_step(c.da, DIV_STEPS - 1 - (k - P_DIVA));
            end else if (k >= P_DIVC && k < P_DIVC + DIV_STEPS) begin
                c.da = f_div_step(c.da, DIV_STEPS - 1 - (k - P_DIVC));
            end else if (k >= P_DIVB && k < P_DIVB + DIV_STEPS) begin
                c.da = f_div_step(c.da, DIV_STEPS - 1 - (k - P_DIVB));
                c.db = f_div_step(c.db, DIV_STEPS - 1 - (k - P_DIVB));
            end else if (k == P_CG) begin
                c.cg = f_div_done(c.da);
            end else if (k == P_T) begin
                c.ty = f_qmul(c.cg, c.by);
                c.tz = f_qmul(c.cg, c.bz);
            end else if (k == P_TSQ) begin
                c.t0 = f_qmul(c.ty, c.ty);
                c.t1 = f_qmul(c.tz, c.tz);
            end else if (k == P_SQT) begin
                // Both rotation divides share the divisor 1 + Ty^2 + Tz^2.
                c.t2 = f_qadd(f_qadd(ONE, c.t0), c.t1);
                c.da = f_div_init(33'(c.ty) <<< 1, c.t2);
                c.db = f_div_init(33'(c.tz) <<< 1, c.t2);
            end else if (k == P_S) begin
                c.sy = f_div_done(c.da);
                c.sz = f_div_done(c.db);
            end else if (k == P_PROD) begin
                c.a1 = f_qmul(c.sz, c.tz);
                c.a2 = f_qmul(c.sy, c.ty);
                c.a3 = f_qmul(c.sz, c.ty);
                c.a4 = f_qmul(c.sy, c.tz);
            end else if (k == P_MAT) begin
                // Boris rotation matrix with no x component of T or S.
                c.mat[0] = f_qsub(f_qsub(ONE, c.a1), c.a2);
                c.mat[1] = c.sz;
                c.mat[2] = f_qsub('0, c.sy);
                c.mat[3] = f_qsub('0, c.sz);
                c.mat[4] = f_qsub(ONE, c.a1);
                c.mat[5] = c.a3;
                c.mat[6] = c.sy;
                c.mat[7] = c.a4;
                c.mat[8] = f_qsub(ONE, c.a2);
            end else if (k == P_MUL9) begin
                for (int r = 0; r < 3; r++) begin
                    c.mat[3*r]   = f_qmul(c.mat[3*r],   c.mx);
                    c.mat[3*r+1] = f_qmul(c.mat[3*r+1], c.my);
                    c.mat[3*r+2] = f_qmul(c.mat[3*r+2], c.mz);
                end
            end else if (k == P_DOT) begin
                c.nx = f_qadd(f_qadd(c.mat[0], c.mat[1]), c.mat[2]);
                c.ny = f_qadd(f_qadd(c.mat[3], c.mat[4]), c.mat[5]);
                c.nz = f_qadd(f_qadd(c.mat[6], c.mat[7]), c.mat[8]);
            end else if (k == P_SHIFT) begin
                c.shift = f_div_done(c.da);
            end else if (k == P_OUT) begin
                c.npos = f_qadd(c.x1, c.shift);
                c.ovs  = (c.shift >= ONE);
            end
            n_ctx[k] = c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STG-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_STG; k++) begin
                r_ctx[k] <= n_ctx[k];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[N_STG-1];
    assign o_m_axis_tdata  = {r_ctx[N_STG-1].oldp, r_ctx[N_STG-1].npos,
                              r_ctx[N_STG-1].nz, r_ctx[N_STG-1].ny, r_ctx[N_STG-1].nx};
    assign o_m_axis_tuser  = r_ctx[N_STG-1].ovs;

    // A stall freezes every valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld == $past(r_vld))
        else $error("pipeline moved during a stall");

    // Gamma is never below one, so the first divider sees a safe divisor.
    a_gamma_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[P_DIVA0] |-> r_ctx[P_DIVA0].da.den >= 32'(ONE))
        else $error("gamma below one");

    // The rotation divisor is at least one.
    a_sqt_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[P_SQT] |-> r_ctx[P_SQT].db.den >= 32'(ONE))
        else $error("rotation divisor below one");

    // A finished restoring divide leaves a remainder below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[P_SHIFT-1] |-> r_ctx[P_SHIFT-1].da.rem < {1'b0, r_ctx[P_SHIFT-1].da.den})
        else $error("divider remainder out of range");

endmodule
